[rtl/swm_pkg.sv]
// Shared types, constants and the compare function of the sliding window maximum block.
`default_nettype none

package swm_pkg;

   // Sizes of the data path.
   localparam int MAX_WINDOW = 64;
   localparam int COORD_BITS = 10;
   localparam int VALUE_BITS = 64;
   localparam int WIN_BITS   = 7;

   // One cell per older item that a window can reach back to.
   localparam int NUM_CELLS = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
   localparam int TAP_BITS  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

   // One value with its coordinate tag.
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [COORD_BITS-1:0]        x;
      logic [COORD_BITS-1:0]        y;
      logic [COORD_BITS-1:0]        z;
   } entry_type;

   // Control that the top level hands to the cell chain.
   typedef struct packed {
      logic                shift;    // a word is accepted this cycle
      logic                restart;  // the word opens a new line
      logic                single;   // the window holds only the current word
      logic [TAP_BITS-1:0] tap;      // cell that holds the rest of the window
   } shift_ctl_type;

   // Larger of two entries; on equal values the newer one wins.
   function automatic entry_type keep_max(input entry_type older, input entry_type newer);
      keep_max = ($signed(newer.value) >= $signed(older.value)) ? newer : older;
   endfunction

endpackage

`default_nettype wire

[rtl/swm_cell.sv]
// One cell of the chain: holds the maximum over a fixed number of the latest words.
`default_nettype none

module swm_cell
   import swm_pkg::*;
(
   input  wire logic          clock,
   input  wire shift_ctl_type ctl,
   input  wire entry_type     prev_entry,
   input  wire entry_type     new_entry,
   output entry_type          entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // The neighbor's span grows by the new word; a line start leaves only the new word.
   always_comb begin
      entry_in = ctl.restart ? new_entry : keep_max(prev_entry, new_entry);
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

[rtl/swm_chain.sv]
// Row of maximum cells and the tap that forms the window result.
`default_nettype none

module swm_chain
   import swm_pkg::*;
(
   input  wire logic          clock,
   input  wire shift_ctl_type ctl,
   input  wire entry_type     new_entry,
   output entry_type          result
);

   // Cell i holds the maximum over the i+1 latest words of the line.
   entry_type cell_q [NUM_CELLS];
   entry_type tap_entry;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      entry_type prev_entry;

      if (i == 0) begin : g_first
         assign prev_entry = new_entry;
      end else begin : g_rest
         assign prev_entry = cell_q[i-1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .prev_entry (prev_entry),
         .new_entry  (new_entry),
         .entry      (cell_q[i])
      );
   end

   // The window is the new word plus the span held by the tapped cell.
   always_comb begin
      tap_entry = cell_q[ctl.tap];
      if (ctl.restart || ctl.single) begin
         result = new_entry;
      end else begin
         result = keep_max(tap_entry, new_entry);
      end
   end

endmodule

`default_nettype wire

[rtl/sliding_window_max_with_tag.sv]
// Top level of the sliding window maximum: handshake, window register and result register.
// Latency: the result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while no result is stalled; every cell of the chain updates in the accepting cycle.
// A stalled result holds the input off until it is taken; the output register parts both sides.
// Reset (synchronous): no result pending, window length 1, and the next word opens a line.
// The cells themselves need no clearing, since the first word after reset reloads them all.
`default_nettype none

module sliding_window_max_with_tag
   import swm_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [VALUE_BITS-1:0] req_sample_value,
   input  wire logic [COORD_BITS-1:0]        req_tag_x,
   input  wire logic [COORD_BITS-1:0]        req_tag_y,
   input  wire logic [COORD_BITS-1:0]        req_tag_z,
   input  wire logic                         req_line_start,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [VALUE_BITS-1:0]      rsp_max_value,
   output logic [COORD_BITS-1:0]             rsp_max_x,
   output logic [COORD_BITS-1:0]             rsp_max_y,
   output logic [COORD_BITS-1:0]             rsp_max_z,
   input  wire logic                         csr_write_en,
   input  wire logic [WIN_BITS-1:0]          csr_write_data
);

   logic [WIN_BITS-1:0] win_len_ff;
   logic [WIN_BITS-1:0] live_ff;
   logic [WIN_BITS-1:0] live_in;
   logic [WIN_BITS-1:0] win_eff;
   logic [WIN_BITS-1:0] reach;
   logic                started_ff;
   logic                rsp_valid_ff;
   entry_type           rsp_entry_ff;
   entry_type           new_entry;
   entry_type           result;
   shift_ctl_type       ctl;
   logic                accept;

   // Window length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= WIN_BITS'(1);
      end else if (csr_write_en) begin
         win_len_ff <= csr_write_data;
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign new_entry = '{value: req_sample_value, x: req_tag_x, y: req_tag_y, z: req_tag_z};

   // Chain control: a length of zero acts as one, long windows saturate.
   // The earlier words still in the window grow by one per word and are cut by the
   // current length; a word that once fell out of the window never comes back.
   always_comb begin
      if (win_len_ff == '0) begin
         win_eff = WIN_BITS'(1);
      end else if (int'(win_len_ff) > MAX_WINDOW) begin
         win_eff = WIN_BITS'(MAX_WINDOW);
      end else begin
         win_eff = win_len_ff;
      end
      ctl.shift   = accept;
      ctl.restart = req_line_start || !started_ff;
      if (ctl.restart) begin
         reach = '0;
      end else if (live_ff < win_eff - WIN_BITS'(1)) begin
         reach = live_ff;
      end else begin
         reach = win_eff - WIN_BITS'(1);
      end
      ctl.single = (reach == '0);
      ctl.tap    = (reach == '0) ? '0 : TAP_BITS'(reach - WIN_BITS'(1));
      live_in    = reach + WIN_BITS'(1);
   end

   swm_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .new_entry (new_entry),
      .result    (result)
   );

   // The first word after reset behaves as a line start.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else if (accept) begin
         started_ff <= 1'b1;
      end
   end

   // Count of earlier words that the next word may still see.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else if (accept) begin
         live_ff <= live_in;
      end
   end

   // Result register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_entry_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_entry_ff.value;
   assign rsp_max_x     = rsp_entry_ff.x;
   assign rsp_max_y     = rsp_entry_ff.y;
   assign rsp_max_z     = rsp_entry_ff.z;

endmodule

`default_nettype wire

[rtl/swm_checker.sv]
// Port level checks of the sliding window maximum, bound to the top level.
`default_nettype none

module swm_checker
   import swm_pkg::*;
(
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic signed [VALUE_BITS-1:0] req_sample_value,
   input wire logic [COORD_BITS-1:0]        req_tag_x,
   input wire logic [COORD_BITS-1:0]        req_tag_y,
   input wire logic [COORD_BITS-1:0]        req_tag_z,
   input wire logic                         req_line_start,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic signed [VALUE_BITS-1:0] rsp_max_value,
   input wire logic [COORD_BITS-1:0]        rsp_max_x,
   input wire logic [COORD_BITS-1:0]        rsp_max_y,
   input wire logic [COORD_BITS-1:0]        rsp_max_z
);

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every accepted word gives a result in the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted word gave no result");

   // A stalled result holds off the input side.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while a result is stalled");

   // A line start word is its own maximum.
   a_line_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_line_start) |=>
         (rsp_max_value == $past(req_sample_value)) && (rsp_max_x == $past(req_tag_x)) &&
         (rsp_max_y == $past(req_tag_y)) && (rsp_max_z == $past(req_tag_z)))
      else $error("line start word not returned as maximum");

   // A stalled result keeps its value and its x tag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_max_value) && $stable(rsp_max_x))
      else $error("stalled result changed");

endmodule

bind sliding_window_max_with_tag swm_checker u_swm_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the sliding window maximum: table-driven and random words, predicted.
`timescale 1ns / 1ps

module tb_top;
   import swm_pkg::*;

   localparam int POS_BITS = 10;
   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

   // One input word as the bench sees it.
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [COORD_BITS-1:0]        x;
      logic [COORD_BITS-1:0]        y;
      logic [COORD_BITS-1:0]        z;
      logic                         line_start;
   } sample_word_type;

   // A window candidate: the entry and its position in the line.
   typedef struct packed {
      entry_type           item;
      logic [POS_BITS-1:0] pos;
   } window_cand_type;

   // One row of the directed table.
   typedef struct packed {
      logic                write_win;
      logic [WIN_BITS-1:0] win;
      sample_word_type     word;
      logic                typed;
      entry_type           want;
   } directed_row_type;

   // How the values of one random line are shaped.
   typedef enum int {
      SHAPE_SMALL,
      SHAPE_FULL,
      SHAPE_FALLING,
      SHAPE_RISING,
      SHAPE_EXTREME
   } value_shape_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [VALUE_BITS-1:0] req_sample_value;
   logic [COORD_BITS-1:0]        req_tag_x;
   logic [COORD_BITS-1:0]        req_tag_y;
   logic [COORD_BITS-1:0]        req_tag_z;
   logic                         req_line_start;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [VALUE_BITS-1:0] rsp_max_value;
   logic [COORD_BITS-1:0]        rsp_max_x;
   logic [COORD_BITS-1:0]        rsp_max_y;
   logic [COORD_BITS-1:0]        rsp_max_z;
   logic                         csr_write_en;
   logic [WIN_BITS-1:0]          csr_write_data;

   // Predictor state: window register, candidate list and line position.
   logic [WIN_BITS-1:0] win_len;
   window_cand_type     window_cands[$];
   logic [POS_BITS-1:0] line_pos;

   entry_type        expected_max[$];
   directed_row_type directed_rows[$];
   int               mismatch_count = 0;
   bit               quiet = 1'b0;
   int               stall_left = 0;

   sliding_window_max_with_tag i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_tag_x        (req_tag_x),
      .req_tag_y        (req_tag_y),
      .req_tag_z        (req_tag_z),
      .req_line_start   (req_line_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_x        (rsp_max_x),
      .rsp_max_y        (rsp_max_y),
      .rsp_max_z        (rsp_max_z),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the window maximum by one word and return the expected result.
   function automatic entry_type window_max_step(input sample_word_type w);
      int unsigned         span;
      logic [POS_BITS-1:0] pos;
      logic [POS_BITS-1:0] age;
      window_cand_type     fresh;
      span = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : win_len);
      if (w.line_start) begin
         window_cands.delete();
         line_pos = '0;
      end
      pos = line_pos;
      // Expired candidates leave at the old end.
      while (window_cands.size() > 0) begin
         age = pos - window_cands[0].pos;
         if (age < span) break;
         void'(window_cands.pop_front());
      end
      // Candidates not larger than the new value can never win again.
      while (window_cands.size() > 0 && window_cands[$].item.value <= w.value)
         void'(window_cands.pop_back());
      if (window_cands.size() >= MAX_WINDOW)
         void'(window_cands.pop_front());
      fresh.item.value = w.value;
      fresh.item.x = w.x;
      fresh.item.y = w.y;
      fresh.item.z = w.z;
      fresh.pos = pos;
      window_cands.push_back(fresh);
      line_pos = pos + 1'b1;
      return window_cands[0].item;
   endfunction

   // Result channel back-pressure: random stall bursts, none in the quiet part.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= (stall_left == 1);
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(1, 10);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin : check_results
      entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_max.size() == 0) begin
            $error("result word with no expectation: value %0d", rsp_max_value);
            mismatch_count++;
         end else begin
            want = expected_max.pop_front();
            if (rsp_max_value !== want.value) begin
               $error("max_value: expected %0d, got %0d", want.value, rsp_max_value);
               mismatch_count++;
            end
            if (rsp_max_x !== want.x) begin
               $error("max_x: expected %0d, got %0d", want.x, rsp_max_x);
               mismatch_count++;
            end
            if (rsp_max_y !== want.y) begin
               $error("max_y: expected %0d, got %0d", want.y, rsp_max_y);
               mismatch_count++;
            end
            if (rsp_max_z !== want.z) begin
               $error("max_z: expected %0d, got %0d", want.z, rsp_max_z);
               mismatch_count++;
            end
         end
      end
   end

   // Present one word and hold it until the block takes it.
   task automatic send_word(input sample_word_type w);
      req_valid <= 1'b1;
      req_sample_value <= w.value;
      req_tag_x <= w.x;
      req_tag_y <= w.y;
      req_tag_z <= w.z;
      req_line_start <= w.line_start;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random sender gap, skipped in the quiet part.
   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Write the window register once all results are in and the block has settled.
   task automatic set_window(input logic [WIN_BITS-1:0] len);
      req_valid <= 1'b0;
      while (expected_max.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_en <= 1'b0;
      win_len = len;
   endtask

   task automatic add_row(input logic write_win, input logic [WIN_BITS-1:0] win,
                          input logic signed [VALUE_BITS-1:0] value,
                          input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                          input logic [COORD_BITS-1:0] z, input logic line_start,
                          input logic typed);
      directed_row_type row;
      row.write_win = write_win;
      row.win = win;
      row.word = '{value: value, x: x, y: y, z: z, line_start: line_start};
      row.typed = typed;
      // Typed rows all return the word itself: window of one, line start or new maximum.
      row.want = '{value: value, x: x, y: y, z: z};
      directed_rows.push_back(row);
   endtask

   // One line of random words; the first carries first_start, the rest rarely a stray start when noise is set.
   task automatic run_line(input int len, input logic first_start, input value_shape_type shape,
                           input bit noise);
      sample_word_type              w;
      logic signed [VALUE_BITS-1:0] base;
      int                           k;
      int                           pick;
      base = {$urandom, $urandom};
      for (k = 0; k < len; k++) begin
         w.line_start = (k == 0) ? first_start : (noise && $urandom_range(0, 49) == 0);
         case (shape)
            SHAPE_SMALL: begin
               pick = $urandom_range(0, 6);
               w.value = pick - 3;
            end
            SHAPE_FULL: w.value = {$urandom, $urandom};
            SHAPE_FALLING: w.value = base - k;
            SHAPE_RISING: w.value = base + k;
            default: begin
               pick = $urandom_range(0, 3);
               w.value = (pick == 0) ? VAL_MAX : (pick == 1) ? VAL_MIN : (pick == 2) ? 0 : -1;
            end
         endcase
         w.x = $urandom_range(0, 1023);
         w.y = $urandom_range(0, 1023);
         w.z = $urandom_range(0, 1023);
         maybe_gap();
         send_word(w);
         expected_max.push_back(window_max_step(w));
      end
   endtask

   // Random phases: a window setting, then lines until the phase has enough words.
   task automatic run_phase(input logic [WIN_BITS-1:0] len, input int words);
      int              total;
      int              line_len;
      logic            first_start;
      value_shape_type shape;
      set_window(len);
      total = 0;
      // Most phases open a line; the rest change the window in the middle of one.
      first_start = ($urandom_range(0, 3) != 0);
      while (total < words) begin
         line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
         shape = ($urandom_range(0, 2) == 0) ? SHAPE_SMALL :
                                               value_shape_type'($urandom_range(0, 4));
         run_line(line_len, first_start, shape, 1'b1);
         first_start = 1'b1;
         total += line_len;
      end
   endtask

   // Main sequence: reset, directed table, random phases, full-list line, quiet tail.
   initial begin : stimulus
      directed_row_type    row;
      entry_type           pred;
      int                  ph;
      int                  pick;
      logic [WIN_BITS-1:0] len;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample_value <= '0;
      req_tag_x <= '0;
      req_tag_y <= '0;
      req_tag_z <= '0;
      req_line_start <= 1'b0;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      win_len = 1;
      line_pos = '0;
      window_cands.delete();

      // Window of one after reset, no line start yet, value and tag extremes.
      add_row(0, 0, 5, 1, 2, 3, 0, 1);
      add_row(0, 0, VAL_MAX, 1023, 1023, 1023, 0, 1);
      add_row(0, 0, VAL_MIN, 0, 0, 0, 1, 1);
      add_row(0, 0, -1, 'h2AA, 'h155, 'h3FF, 0, 1);
      // Window zero acts as one.
      add_row(1, 0, 0, 'h155, 'h2AA, 0, 1, 1);
      add_row(0, 0, 100, 7, 8, 9, 0, 1);
      // Window too long saturates; equal values let the newest win.
      add_row(1, 127, 10, 11, 12, 13, 1, 1);
      add_row(0, 0, 3, 14, 15, 16, 0, 0);
      add_row(0, 0, 10, 17, 18, 19, 0, 0);
      add_row(0, 0, VAL_MIN, 20, 21, 22, 0, 0);
      add_row(0, 0, VAL_MAX, 23, 24, 25, 0, 1);
      // Window shortened in the middle of a line, then runs of equal values.
      add_row(1, 3, -5, 26, 27, 28, 0, 0);
      add_row(0, 0, -6, 29, 30, 31, 0, 0);
      add_row(0, 0, -7, 32, 33, 34, 0, 0);
      add_row(0, 0, -7, 35, 36, 37, 0, 0);
      add_row(0, 0, -7, 38, 39, 40, 0, 0);
      add_row(1, 2, 0, 41, 42, 43, 0, 0);
      // A line start clears the list even after a maximum.
      add_row(0, 0, VAL_MAX, 1, 1, 1, 1, 1);
      add_row(0, 0, VAL_MIN, 2, 2, 2, 1, 1);
      add_row(1, 64, 1, 3, 3, 3, 1, 1);
      add_row(0, 0, 2, 4, 4, 4, 0, 0);
      add_row(0, 0, 2, 5, 5, 5, 0, 0);
      add_row(0, 0, -3, 6, 6, 6, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.write_win) set_window(row.win);
         maybe_gap();
         send_word(row.word);
         pred = window_max_step(row.word);
         expected_max.push_back(row.typed ? row.want : pred);
      end

      // Random phases, the extreme window settings first.
      for (ph = 0; ph < 11; ph++) begin
         pick = $urandom_range(0, 3);
         case (ph)
            0: len = WIN_BITS'(64);
            1: len = WIN_BITS'(1);
            2: len = WIN_BITS'(127);
            3: len = WIN_BITS'(0);
            default: len = (pick == 0) ? WIN_BITS'(2) : (pick == 1) ? WIN_BITS'(3) :
                           (pick == 2) ? WIN_BITS'($urandom_range(1, 8)) :
                                         WIN_BITS'($urandom_range(0, 127));
         endcase
         run_phase(len, 6);
      end

      // One falling line at full window length keeps every candidate in the list.
      set_window(WIN_BITS'(64));
      run_line(64, 1'b1, SHAPE_FALLING, 1'b0);

      // Quiet tail with no idling on either side.
      quiet = 1'b1;
      run_phase(WIN_BITS'($urandom_range(2, 64)), 24);

      req_valid <= 1'b0;
      while (expected_max.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
